@@ hdl/swcc_pkg.sv @@
// Shared constants, types and helpers for the packed clause counter unit.
package swcc_pkg;

  // Word layout and field geometry
  localparam int WORD_W          = 64;
  localparam int FIELD_W         = 3;
  localparam int FIELDS_PER_WORD = 21;
  localparam int MASK_W          = 21;
  localparam int USED_W          = 5;
  localparam int MODE_W          = 2;

  // Score arithmetic
  localparam int SCORE_WIDTH = 16;
  localparam int TOTAL_W     = 16;
  localparam int CNT_W       = $clog2(FIELDS_PER_WORD + 1);
  localparam int DELTA_W     = CNT_W + 1;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_FLIP  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCORE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNSAT = 2'd2;

  // Mask with the low bit of every field in use set
  function automatic logic [WORD_W-1:0] field_low_mask();
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < FIELDS_PER_WORD; i++) begin
      m[FIELD_W*i] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [WORD_W-1:0] LOW_MASK = field_low_mask();

  // One input transaction as held in the input register
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [WORD_W-1:0] counter_word;
    logic [WORD_W-1:0] pos_vector;
    logic [WORD_W-1:0] neg_vector;
    logic              became_true;
    logic              negative_literal;
    logic [USED_W-1:0] used_fields;
    logic              last_word;
  } in_item_t;

  // Per-word evaluation handed to the accumulate stage
  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [WORD_W-1:0]         new_word;
    logic signed [DELTA_W-1:0] delta;
    logic [MASK_W-1:0]         mask;
    logic                      last_word;
  } eval_t;

endpackage

@@ hdl/swcc_ifs.sv @@
// Valid/ready channel interfaces for the input and result transactions.
interface swcc_in_if;
  logic                          valid;
  logic                          ready;
  logic [swcc_pkg::MODE_W-1:0]   mode;
  logic [swcc_pkg::WORD_W-1:0]   counter_word;
  logic [swcc_pkg::WORD_W-1:0]   pos_vector;
  logic [swcc_pkg::WORD_W-1:0]   neg_vector;
  logic                          became_true;
  logic                          negative_literal;
  logic [swcc_pkg::USED_W-1:0]   used_fields;
  logic                          last_word;

  modport source (
    output valid, mode, counter_word, pos_vector, neg_vector, became_true,
           negative_literal, used_fields, last_word,
    input  ready
  );
  modport sink (
    input  valid, mode, counter_word, pos_vector, neg_vector, became_true,
           negative_literal, used_fields, last_word,
    output ready
  );
endinterface

interface swcc_out_if;
  logic                               valid;
  logic                               ready;
  logic [swcc_pkg::WORD_W-1:0]        new_counter_word;
  logic signed [swcc_pkg::TOTAL_W-1:0] score_total;
  logic                               score_valid;
  logic [swcc_pkg::MASK_W-1:0]        unsat_mask;

  modport source (
    output valid, new_counter_word, score_total, score_valid, unsat_mask,
    input  ready
  );
  modport sink (
    input  valid, new_counter_word, score_total, score_valid, unsat_mask,
    output ready
  );
endinterface

@@ hdl/swar_clause_counter_unit_top.sv @@
// Top level of the packed clause counter unit: input, evaluate and result stages.
//
// Each input transaction carries one 64-bit word of packed three-bit clause
// counters and produces exactly one result transaction. The unit is a
// three-register pipeline (input register, evaluation register, result
// register) and accepts a new word every cycle while results are taken; results
// are offered from the result register. Back-pressure on the result side holds
// the result register, earlier stages still advance into any empty slot,
// and the input stalls only once all three registers hold a word. Flip mode
// returns the updated word, unsat mode returns the mask of zero counters
// among the used fields, and score mode adds make minus break for each word
// to a saturating accumulator in the last stage, reporting the total and
// clearing it on the last word of a run. The accumulator is the only state
// carried between words and resets to zero.
module swar_clause_counter_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  swcc_in_if.sink     in_if,
  swcc_out_if.source  out_if
);

  localparam int SW = swcc_pkg::SCORE_WIDTH;

  localparam logic signed [SW:0] SAT_HI = {2'b00, {(SW-1){1'b1}}};
  localparam logic signed [SW:0] SAT_LO = {2'b11, {(SW-1){1'b0}}};
  localparam logic signed [31:0] TOT_HI = (32'sd1 <<< (swcc_pkg::TOTAL_W - 1)) - 32'sd1;
  localparam logic signed [31:0] TOT_LO = -TOT_HI - 32'sd1;

  // Pipeline state
  logic                 a_v_r;
  swcc_pkg::in_item_t   a_item_r;
  logic                 b_v_r;
  swcc_pkg::eval_t      b_r;
  logic                 out_v_r;
  logic [swcc_pkg::WORD_W-1:0]         out_word_r;
  logic signed [swcc_pkg::TOTAL_W-1:0] out_total_r;
  logic                                out_sv_r;
  logic [swcc_pkg::MASK_W-1:0]         out_mask_r;
  logic signed [SW-1:0] acc_r;
  logic signed [SW-1:0] acc_nxt;

  swcc_pkg::in_item_t   in_item;
  swcc_pkg::eval_t      eval_res;

  logic adv_o;
  logic adv_b;
  logic in_fire;

  logic signed [SW:0]   acc_sum;
  logic signed [SW-1:0] acc_sat;
  logic signed [31:0]   acc_ext;
  logic signed [swcc_pkg::TOTAL_W-1:0] total_clip;
  logic                 is_score;

  // Stage handshakes: a stage moves when the next one is empty or moving
  assign adv_o       = b_v_r && (!out_v_r || out_if.ready);
  assign adv_b       = a_v_r && (!b_v_r || adv_o);
  assign in_if.ready = !a_v_r || adv_b;
  assign in_fire     = in_if.valid && in_if.ready;

  // Gather the input payload
  always_comb begin
    in_item.mode             = in_if.mode;
    in_item.counter_word     = in_if.counter_word;
    in_item.pos_vector       = in_if.pos_vector;
    in_item.neg_vector       = in_if.neg_vector;
    in_item.became_true      = in_if.became_true;
    in_item.negative_literal = in_if.negative_literal;
    in_item.used_fields      = in_if.used_fields;
    in_item.last_word        = in_if.last_word;
  end

  swcc_word_eval u_eval (
    .item (a_item_r),
    .res  (eval_res)
  );

  // Saturating accumulate and output clip
  always_comb begin
    is_score = (b_r.mode == swcc_pkg::MODE_SCORE);
    acc_sum  = $signed({acc_r[SW-1], acc_r}) + (SW+1)'(b_r.delta);
    if (acc_sum > SAT_HI) begin
      acc_sat = SAT_HI[SW-1:0];
    end else if (acc_sum < SAT_LO) begin
      acc_sat = SAT_LO[SW-1:0];
    end else begin
      acc_sat = acc_sum[SW-1:0];
    end
    acc_ext = 32'(acc_sat);
    if (acc_ext > TOT_HI) begin
      total_clip = TOT_HI[swcc_pkg::TOTAL_W-1:0];
    end else if (acc_ext < TOT_LO) begin
      total_clip = TOT_LO[swcc_pkg::TOTAL_W-1:0];
    end else begin
      total_clip = acc_ext[swcc_pkg::TOTAL_W-1:0];
    end
    acc_nxt = acc_r;
    if (is_score) begin
      acc_nxt = b_r.last_word ? '0 : acc_sat;
    end
  end

  // Control state: stage valids and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      acc_r   <= '0;
    end else begin
      if (in_if.ready) begin
        a_v_r <= in_if.valid;
      end
      if (!b_v_r || adv_o) begin
        b_v_r <= adv_b;
      end
      if (!out_v_r || out_if.ready) begin
        out_v_r <= adv_o;
      end
      if (adv_o) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // Payload registers: load on advance, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_item_r <= in_item;
    end
    if (adv_b) begin
      b_r <= eval_res;
    end
    if (adv_o) begin
      out_word_r  <= b_r.new_word;
      out_mask_r  <= b_r.mask;
      out_sv_r    <= is_score && b_r.last_word;
      out_total_r <= (is_score && b_r.last_word) ? total_clip : '0;
    end
  end

  // Drive the result transaction
  assign out_if.valid            = out_v_r;
  assign out_if.new_counter_word = out_word_r;
  assign out_if.score_total      = out_total_r;
  assign out_if.score_valid      = out_sv_r;
  assign out_if.unsat_mask       = out_mask_r;

endmodule

@@ hdl/swcc_word_eval.sv @@
// Per-word evaluation: flip update, make/break field counts, zero-field mask.
module swcc_word_eval (
  input  swcc_pkg::in_item_t item,
  output swcc_pkg::eval_t    res
);

  // Count fields with any bit set in the given vector
  function automatic logic [swcc_pkg::CNT_W-1:0] count_fields(
    input logic [swcc_pkg::WORD_W-1:0] bits
  );
    logic [swcc_pkg::WORD_W-1:0] merged;
    logic [swcc_pkg::CNT_W-1:0]  cnt;
    merged = (bits | (bits >> 1) | (bits >> 2)) & swcc_pkg::LOW_MASK;
    cnt    = '0;
    for (int i = 0; i < swcc_pkg::FIELDS_PER_WORD; i++) begin
      cnt = cnt + swcc_pkg::CNT_W'(merged[swcc_pkg::FIELD_W*i]);
    end
    return cnt;
  endfunction

  logic [swcc_pkg::WORD_W-1:0]  flip_word;
  logic [swcc_pkg::WORD_W-1:0]  trial_word;
  logic [swcc_pkg::WORD_W-1:0]  made_bits;
  logic [swcc_pkg::WORD_W-1:0]  broken_bits;
  logic [swcc_pkg::CNT_W-1:0]   make_cnt;
  logic [swcc_pkg::CNT_W-1:0]   break_cnt;
  logic [swcc_pkg::USED_W-1:0]  used_cl;
  logic [swcc_pkg::MASK_W-1:0]  zero_mask;

  // Flip update with wrapping arithmetic
  always_comb begin
    if (item.became_true) begin
      flip_word = item.counter_word + item.pos_vector - item.neg_vector;
    end else begin
      flip_word = item.counter_word - item.pos_vector + item.neg_vector;
    end
  end

  // Trial word and newly set / newly cleared bits
  assign trial_word  = item.negative_literal ? item.counter_word - item.pos_vector
                                             : item.counter_word + item.pos_vector;
  assign made_bits   = ~item.counter_word & trial_word;
  assign broken_bits = item.counter_word & ~trial_word;
  assign make_cnt    = count_fields(made_bits);
  assign break_cnt   = count_fields(broken_bits);

  // Clamp the used count and flag zero counters below it
  always_comb begin
    if (item.used_fields > swcc_pkg::USED_W'(swcc_pkg::FIELDS_PER_WORD)) begin
      used_cl = swcc_pkg::USED_W'(swcc_pkg::FIELDS_PER_WORD);
    end else begin
      used_cl = item.used_fields;
    end
    zero_mask = '0;
    for (int i = 0; i < swcc_pkg::FIELDS_PER_WORD; i++) begin
      zero_mask[i] = (swcc_pkg::USED_W'(i) < used_cl) &&
                     (item.counter_word[swcc_pkg::FIELD_W*i +: swcc_pkg::FIELD_W] == '0);
    end
  end

  // Assemble the result by mode
  always_comb begin
    res.mode      = item.mode;
    res.last_word = item.last_word;
    res.delta     = $signed({1'b0, make_cnt}) - $signed({1'b0, break_cnt});
    res.new_word  = item.counter_word;
    res.mask      = '0;
    case (item.mode)
      swcc_pkg::MODE_FLIP:  res.new_word = flip_word;
      swcc_pkg::MODE_SCORE: res.new_word = item.counter_word;
      swcc_pkg::MODE_UNSAT: res.mask     = zero_mask;
      default:              res.mask     = '0;
    endcase
  end

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the packed clause counter unit: flip, score and unsat modes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode value that the unit passes through untouched
  localparam logic [swcc_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int SCORE_MAX   = (1 << (swcc_pkg::SCORE_WIDTH - 1)) - 1;
  localparam int SCORE_MIN   = -SCORE_MAX - 1;
  localparam int RANDOM_WORDS = 750;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT = 1000;

  localparam logic [swcc_pkg::WORD_W-1:0] ALL_LOW_BITS    = 64'o111111111111111111111;
  localparam logic [swcc_pkg::WORD_W-1:0] ODD_FIELDS_ZERO = 64'o505050505050505050505;

  typedef struct packed {
    logic [swcc_pkg::WORD_W-1:0]         new_word;
    logic signed [swcc_pkg::TOTAL_W-1:0] total;
    logic                                total_valid;
    logic [swcc_pkg::MASK_W-1:0]         mask;
  } word_result_t;

  // Predicts each word's result and checks the unit's results in order
  class clause_word_scoreboard;
    word_result_t expected_q[$];
    int           score_acc;
    int unsigned  errors;

    function new();
      score_acc = 0;
      errors = 0;
    endfunction

    // Count fields with at least one bit set; bit 63 belongs to no field
    static function int fields_touched(logic [swcc_pkg::WORD_W-1:0] bits);
      logic [swcc_pkg::WORD_W-1:0] base;
      logic [swcc_pkg::WORD_W-1:0] merged;
      base = '0;
      for (int i = 0; i < swcc_pkg::FIELDS_PER_WORD; i++) base[swcc_pkg::FIELD_W*i] = 1'b1;
      merged = (bits | (bits >> 1) | (bits >> 2)) & base;
      return $countones(merged);
    endfunction

    function void note_word(swcc_pkg::in_item_t it);
      word_result_t                r;
      logic [swcc_pkg::WORD_W-1:0] t;
      int                          used;
      int                          sum;
      r = '0;
      r.new_word = it.counter_word;
      case (it.mode)
        swcc_pkg::MODE_FLIP: begin
          r.new_word = it.became_true ? it.counter_word + it.pos_vector - it.neg_vector
                                      : it.counter_word - it.pos_vector + it.neg_vector;
        end
        swcc_pkg::MODE_SCORE: begin
          t = it.negative_literal ? it.counter_word - it.pos_vector
                                  : it.counter_word + it.pos_vector;
          sum = score_acc + fields_touched(~it.counter_word & t)
                - fields_touched(it.counter_word & ~t);
          score_acc = (sum > SCORE_MAX) ? SCORE_MAX : (sum < SCORE_MIN) ? SCORE_MIN : sum;
          if (it.last_word) begin
            r.total = score_acc[swcc_pkg::TOTAL_W-1:0];
            r.total_valid = 1'b1;
            score_acc = 0;
          end
        end
        swcc_pkg::MODE_UNSAT: begin
          used = (it.used_fields > swcc_pkg::FIELDS_PER_WORD) ? swcc_pkg::FIELDS_PER_WORD
                                                             : int'(it.used_fields);
          for (int i = 0; i < used; i++) begin
            if (it.counter_word[swcc_pkg::FIELD_W*i +: swcc_pkg::FIELD_W] == '0)
              r.mask[i] = 1'b1;
          end
        end
        default: ;
      endcase
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(word_result_t got);
      word_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, word %h", $time, got.new_word);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.new_word !== want.new_word) begin
        $display("%0t: new_counter_word expected %h actual %h", $time, want.new_word,
                 got.new_word);
        errors++;
      end
      if (got.total !== want.total) begin
        $display("%0t: score_total expected %0d actual %0d", $time, want.total, got.total);
        errors++;
      end
      if (got.total_valid !== want.total_valid) begin
        $display("%0t: score_valid expected %b actual %b", $time, want.total_valid,
                 got.total_valid);
        errors++;
      end
      if (got.mask !== want.mask) begin
        $display("%0t: unsat_mask expected %h actual %h", $time, want.mask, got.mask);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   gaps_on = 1'b1;
  bit   steady_ready = 1'b0;
  bit   hold_req = 1'b0;

  clause_word_scoreboard words = new();

  swcc_in_if  in_if ();
  swcc_out_if out_if ();

  swar_clause_counter_unit_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Counter word with small counts most of the time, raw bits otherwise
  function automatic logic [swcc_pkg::WORD_W-1:0] rand_counters();
    logic [swcc_pkg::WORD_W-1:0] w;
    w = {$urandom, $urandom};
    if ($urandom_range(3) != 0) begin
      for (int i = 0; i < swcc_pkg::FIELDS_PER_WORD; i++)
        w[swcc_pkg::FIELD_W*i +: swcc_pkg::FIELD_W] =
          swcc_pkg::FIELD_W'($urandom_range(0, $urandom_range(0, 7)));
    end
    return w;
  endfunction

  // Occurrence vector: sparse field low bits, sometimes shifted or raw
  function automatic logic [swcc_pkg::WORD_W-1:0] rand_occurrence();
    logic [swcc_pkg::WORD_W-1:0] v;
    int                          sh;
    v = '0;
    sh = ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0;
    if ($urandom_range(4) == 0) return {$urandom, $urandom};
    for (int i = 0; i < swcc_pkg::FIELDS_PER_WORD; i++)
      if ($urandom_range(3) == 0) v[swcc_pkg::FIELD_W*i + sh] = 1'b1;
    return v;
  endfunction

  function automatic swcc_pkg::in_item_t random_item();
    swcc_pkg::in_item_t it;
    it.mode             = swcc_pkg::MODE_W'($urandom_range(3));
    it.counter_word     = {$urandom, $urandom};
    it.pos_vector       = {$urandom, $urandom};
    it.neg_vector       = {$urandom, $urandom};
    it.became_true      = 1'($urandom_range(1));
    it.negative_literal = 1'($urandom_range(1));
    it.used_fields      = swcc_pkg::USED_W'($urandom_range(31));
    it.last_word        = 1'($urandom_range(1));
    return it;
  endfunction

  // Offer one word and hold it until the unit accepts it; call at a falling edge
  task automatic send_word(input swcc_pkg::in_item_t it);
    while (gaps_on && $urandom_range(99) < 17) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.mode             <= it.mode;
    in_if.counter_word     <= it.counter_word;
    in_if.pos_vector       <= it.pos_vector;
    in_if.neg_vector       <= it.neg_vector;
    in_if.became_true      <= it.became_true;
    in_if.negative_literal <= it.negative_literal;
    in_if.used_fields      <= it.used_fields;
    in_if.last_word        <= it.last_word;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [swcc_pkg::MODE_W-1:0] mode,
                             input logic [swcc_pkg::WORD_W-1:0] word,
                             input logic [swcc_pkg::WORD_W-1:0] pv,
                             input logic [swcc_pkg::WORD_W-1:0] nv,
                             input logic bt, input logic nl,
                             input logic [swcc_pkg::USED_W-1:0] used,
                             input logic last);
    swcc_pkg::in_item_t it;
    it.mode             = mode;
    it.counter_word     = word;
    it.pos_vector       = pv;
    it.neg_vector       = nv;
    it.became_true      = bt;
    it.negative_literal = nl;
    it.used_fields      = used;
    it.last_word        = last;
    send_word(it);
  endtask

  // Check every result transaction and predict every accepted input transaction
  always @(posedge clk) begin : monitor
    word_result_t       got;
    swcc_pkg::in_item_t seen;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.new_word    = out_if.new_counter_word;
        got.total       = out_if.score_total;
        got.total_valid = out_if.score_valid;
        got.mask        = out_if.unsat_mask;
        words.check_result(got);
      end
      if (in_if.valid && in_if.ready) begin
        seen.mode             = in_if.mode;
        seen.counter_word     = in_if.counter_word;
        seen.pos_vector       = in_if.pos_vector;
        seen.neg_vector       = in_if.neg_vector;
        seen.became_true      = in_if.became_true;
        seen.negative_literal = in_if.negative_literal;
        seen.used_fields      = in_if.used_fields;
        seen.last_word        = in_if.last_word;
        words.note_word(seen);
      end
    end
  end

  // Result side: random stalls, a long hold-off on request, none in steady stretches
  initial begin : result_sink
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_if.ready <= steady_ready || ($urandom_range(99) >= 17);
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    swcc_pkg::in_item_t it;
    swcc_pkg::in_item_t batch[$];
    int                 sent;
    int                 run_len;
    bit                 negl;

    in_if.valid            = 1'b0;
    in_if.mode             = swcc_pkg::MODE_FLIP;
    in_if.counter_word     = '0;
    in_if.pos_vector       = '0;
    in_if.neg_vector       = '0;
    in_if.became_true      = 1'b0;
    in_if.negative_literal = 1'b0;
    in_if.used_fields      = '0;
    in_if.last_word        = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Flip: plain, wrap up, wrap down, last word outside score mode
    send_fields(swcc_pkg::MODE_FLIP, '0, '0, '0, 1'b1, 1'b0, 5'd0, 1'b0);
    send_fields(swcc_pkg::MODE_FLIP, '1, 64'd1, '0, 1'b1, 1'b0, 5'd0, 1'b0);
    send_fields(swcc_pkg::MODE_FLIP, '0, 64'd1, '1, 1'b0, 1'b1, 5'd31, 1'b0);
    send_fields(swcc_pkg::MODE_FLIP, '1, '1, '1, 1'b0, 1'b1, 5'd21, 1'b1);
    // Score: every field made, then carry into the straddling slot
    send_fields(swcc_pkg::MODE_SCORE, '0, ALL_LOW_BITS, '0, 1'b0, 1'b0, 5'd0, 1'b0);
    send_fields(swcc_pkg::MODE_SCORE, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, '0, 1'b0, 1'b0, 5'd0,
                1'b1);
    // Score on a negated literal: borrow through every field, then clear all
    send_fields(swcc_pkg::MODE_SCORE, '0, 64'd1, '1, 1'b1, 1'b1, 5'd31, 1'b0);
    send_fields(swcc_pkg::MODE_SCORE, '1, '1, '0, 1'b0, 1'b1, 5'd0, 1'b1);
    // Score where only bit 63 changes
    send_fields(swcc_pkg::MODE_SCORE, {1'b1, 63'd0}, {1'b1, 63'd0}, '0, 1'b0, 1'b0, 5'd0,
                1'b1);
    // Unsat: no fields, all fields, used count above the field count
    send_fields(swcc_pkg::MODE_UNSAT, '0, '0, '0, 1'b0, 1'b0, 5'd0, 1'b0);
    send_fields(swcc_pkg::MODE_UNSAT, '0, '1, '1, 1'b1, 1'b1, 5'd21, 1'b0);
    send_fields(swcc_pkg::MODE_UNSAT, '0, '0, '0, 1'b0, 1'b0, 5'd22, 1'b0);
    send_fields(swcc_pkg::MODE_UNSAT, '0, '0, '0, 1'b0, 1'b0, 5'd31, 1'b1);
    send_fields(swcc_pkg::MODE_UNSAT, '1, '0, '0, 1'b0, 1'b0, 5'd21, 1'b0);
    send_fields(swcc_pkg::MODE_UNSAT, ODD_FIELDS_ZERO, '0, '0, 1'b0, 1'b0, 5'd10, 1'b0);
    // Spare mode passes the word through
    send_fields(MODE_SPARE, '1, '1, '1, 1'b1, 1'b1, 5'd31, 1'b1);
    send_fields(MODE_SPARE, '0, '0, '0, 1'b0, 1'b0, 5'd0, 1'b0);
    // Score run broken up by last words in other modes
    send_fields(swcc_pkg::MODE_SCORE, '0, ALL_LOW_BITS, '0, 1'b0, 1'b0, 5'd0, 1'b0);
    send_fields(swcc_pkg::MODE_UNSAT, '0, '0, '0, 1'b0, 1'b0, 5'd21, 1'b1);
    send_fields(swcc_pkg::MODE_FLIP, '0, 64'd3, '0, 1'b1, 1'b0, 5'd0, 1'b1);
    send_fields(swcc_pkg::MODE_SCORE, '0, ALL_LOW_BITS, '0, 1'b0, 1'b0, 5'd0, 1'b1);

    // Random part: mostly score runs, with flips, scans and noise between
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      batch.delete();
      case ($urandom_range(99)) inside
        [0:49]: begin
          run_len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
          negl = 1'($urandom_range(1));
          for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(9) == 0) batch.insert(batch.size(), random_item());
            it = random_item();
            it.mode             = swcc_pkg::MODE_SCORE;
            it.counter_word     = rand_counters();
            it.pos_vector       = rand_occurrence();
            it.negative_literal = negl;
            it.last_word        = (k == run_len - 1);
            batch.insert(batch.size(), it);
          end
        end
        [50:69]: begin
          repeat ($urandom_range(1, 4)) begin
            it = random_item();
            it.mode         = swcc_pkg::MODE_FLIP;
            it.counter_word = rand_counters();
            it.pos_vector   = rand_occurrence();
            it.neg_vector   = rand_occurrence();
            batch.insert(batch.size(), it);
          end
        end
        [70:87]: begin
          it = random_item();
          it.mode         = swcc_pkg::MODE_UNSAT;
          it.counter_word = rand_counters();
          it.used_fields  = ($urandom_range(4) == 0)
                            ? swcc_pkg::USED_W'($urandom_range(22, 31))
                            : swcc_pkg::USED_W'($urandom_range(0, 21));
          batch.insert(batch.size(), it);
        end
        default: batch.insert(batch.size(), random_item());
      endcase

      foreach (batch[i]) begin
        // Long result hold-off while words keep coming
        if (sent == 200) hold_req = 1'b1;
        // Pause the input until every outstanding result has come back
        if (sent == 400) begin
          in_if.valid <= 1'b0;
          do @(negedge clk); while (words.pending() != 0);
        end
        steady_ready = (sent >= 450 && sent < 560);
        gaps_on = !steady_ready;
        send_word(batch[i]);
        sent++;
      end
    end

    // Drain: wait for every result, then keep watching for stray results
    in_if.valid <= 1'b0;
    do @(negedge clk); while (words.pending() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (words.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
